// ===== hw/rtl/tlt_pkg.sv =====
// Shared types and constants for the tensor layout transpose block.
// No dependencies; imported by the walk and the top level.
`timescale 1ns / 1ps

package tlt_pkg;

	// register field widths
	localparam int DIR_W   = 2;
	localparam int PLANE_W = 13;
	localparam int CHAN_W  = 7;
	localparam int TOTAL_W = PLANE_W + CHAN_W;

	// stream field widths
	localparam int ELEM_IN_W  = 32;
	localparam int ELEM_OUT_W = 32;

	// APB port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_DIRECTION  = 2'd0;
	localparam logic [1:0] REG_PLANE_SIZE = 2'd1;
	localparam logic [1:0] REG_CHANNELS   = 2'd2;

	// direction codes; anything else reads in order
	localparam logic [DIR_W-1:0] DIR_COPY = 2'd0;
	localparam logic [DIR_W-1:0] DIR_I2P  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_P2I  = 2'd2;

	// item kinds
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_REQ  = 1'b1;

	// register reset values
	localparam logic [DIR_W-1:0]   RST_DIRECTION  = DIR_COPY;
	localparam logic [PLANE_W-1:0] RST_PLANE_SIZE = 13'd1;
	localparam logic [CHAN_W-1:0]  RST_CHANNELS   = 7'd1;

	// parameter defaults
	localparam int DEF_MAX_ELEMS    = 4096;
	localparam int DEF_ELEMENT_BITS = 32;
	localparam int DEF_MAX_CHANNELS = 64;

	typedef struct packed {
		logic [DIR_W-1:0]   direction;
		logic [PLANE_W-1:0] plane_size;
		logic [CHAN_W-1:0]  channels;
	} tlt_cfg_t;

	// walk -> store / output pipeline
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic ready_res;
		logic last;
	} tlt_ctl_t;

endpackage

// ===== hw/rtl/tlt_store.sv =====
// Element buffer: simple dual-port synchronous RAM with a registered read.
// No package dependencies.
`timescale 1ns / 1ps

module tlt_store #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/tlt_walk.sv =====
// Load/emit counters and incremental read address generator.
// Depends on tlt_pkg (config and control structs, direction codes).
`timescale 1ns / 1ps

module tlt_walk #(
	parameter int MAX_ELEMS    = tlt_pkg::DEF_MAX_ELEMS,
	parameter int MAX_CHANNELS = tlt_pkg::DEF_MAX_CHANNELS,
	parameter int AW           = $clog2(MAX_ELEMS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tlt_pkg::tlt_cfg_t cfg,
	input  logic              cfg_wr,
	input  logic              in_go,
	input  logic              func,
	output tlt_pkg::tlt_ctl_t ctl,
	output logic [AW-1:0]     wr_addr,
	output logic [AW-1:0]     rd_addr
);

	import tlt_pkg::*;

	localparam int CW = $clog2(MAX_ELEMS + 1);
	localparam int XW = ((CW > TOTAL_W) ? CW : TOTAL_W) + 1;

	logic [CW-1:0] load_q, emit_q, inner_q, outer_q;
	logic [AW-1:0] addr_q;

	logic [XW-1:0] total_x, inner_len, stride;
	logic          shape_ok, full, can_load, ready, is_last, transposed, inner_wrap;
	logic          do_load, do_emit;

	always_comb begin
		total_x  = XW'(cfg.plane_size) * XW'(cfg.channels);
		shape_ok = (total_x != '0) && (total_x <= XW'(MAX_ELEMS))
		           && (XW'(cfg.channels) <= XW'(MAX_CHANNELS));
		full     = shape_ok && (XW'(load_q) == total_x);
		can_load = shape_ok && (XW'(load_q) < total_x);
		ready    = full && (XW'(emit_q) < total_x);
		is_last  = (XW'(emit_q) + XW'(1)) >= total_x;

		transposed = (cfg.channels != CHAN_W'(1))
		             && ((cfg.direction == DIR_I2P) || (cfg.direction == DIR_P2I));
		// I2P: inner walks pixels, stride channels; P2I: inner walks channels, stride plane
		inner_len  = (cfg.direction == DIR_I2P) ? XW'(cfg.plane_size) : XW'(cfg.channels);
		stride     = (cfg.direction == DIR_I2P) ? XW'(cfg.channels) : XW'(cfg.plane_size);
		inner_wrap = (XW'(inner_q) + XW'(1)) >= inner_len;

		do_load = in_go && (func == FUNC_LOAD) && can_load;
		do_emit = in_go && (func == FUNC_REQ) && ready;

		ctl.wr_en     = do_load;
		ctl.rd_en     = do_emit;
		ctl.ready_res = ready;
		ctl.last      = ready && is_last;
	end

	assign wr_addr = AW'(load_q);
	assign rd_addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q  <= '0;
			emit_q  <= '0;
			inner_q <= '0;
			outer_q <= '0;
			addr_q  <= '0;
		end else if (cfg_wr) begin
			load_q  <= '0;
			emit_q  <= '0;
			inner_q <= '0;
			outer_q <= '0;
			addr_q  <= '0;
		end else begin
			if (do_load) begin
				load_q <= load_q + CW'(1);
			end
			if (do_emit) begin
				if (is_last) begin
					load_q  <= '0;
					emit_q  <= '0;
					inner_q <= '0;
					outer_q <= '0;
					addr_q  <= '0;
				end else begin
					emit_q <= emit_q + CW'(1);
					if (!transposed) begin
						addr_q <= addr_q + AW'(1);
					end else if (inner_wrap) begin
						inner_q <= '0;
						outer_q <= outer_q + CW'(1);
						addr_q  <= AW'(XW'(outer_q) + XW'(1));
					end else begin
						inner_q <= inner_q + CW'(1);
						addr_q  <= AW'(XW'(addr_q) + stride);
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/tensor_layout_transpose.sv =====
// Tensor layout transpose, HWC <-> CHW. Top level: APB registers and output pipeline.
// A request's result is registered in the RAM read stage, then the output register.
// Throughput: one transfer per cycle, load or request, unless the output stalls; the
// buffer RAM takes one write or one read per cycle. Loads produce no output transfer.
// Reset: arst_n clears counters and pipeline valids and restores register defaults;
// buffer contents are undefined until loaded.
// Depends on tlt_pkg, tlt_walk, tlt_store.
`timescale 1ns / 1ps

module tensor_layout_transpose #(
	parameter int MAX_ELEMS    = tlt_pkg::DEF_MAX_ELEMS,
	parameter int ELEMENT_BITS = tlt_pkg::DEF_ELEMENT_BITS,
	parameter int MAX_CHANNELS = tlt_pkg::DEF_MAX_CHANNELS
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tlt_pkg::APB_AW-1:0]      paddr,
	input  logic [tlt_pkg::APB_DW-1:0]      pwdata,
	output logic [tlt_pkg::APB_DW-1:0]      prdata,
	output logic                            pready,

	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [tlt_pkg::ELEM_IN_W-1:0]   s_axis_tdata,   // [31:0] element_in
	input  logic                            s_axis_tuser,   // [0] func

	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tlt_pkg::ELEM_OUT_W-1:0]  m_axis_tdata,   // [31:0] element_out
	output logic                            m_axis_tuser,   // [0] ready_res
	output logic                            m_axis_tlast
);

	import tlt_pkg::*;

	localparam int AW = $clog2(MAX_ELEMS);

	// ---------------------------------------------------------------
	// Configuration registers. Any write to a defined register also
	// restarts the load/emit counters (done inside the walk).
	// ---------------------------------------------------------------
	tlt_cfg_t   cfg_q;
	logic [1:0] reg_idx;
	logic       apb_wr, cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign apb_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_DIRECTION:  cfg_wr = apb_wr;
			REG_PLANE_SIZE: cfg_wr = apb_wr;
			REG_CHANNELS:   cfg_wr = apb_wr;
			default:        cfg_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction  <= RST_DIRECTION;
			cfg_q.plane_size <= RST_PLANE_SIZE;
			cfg_q.channels   <= RST_CHANNELS;
		end else if (apb_wr) begin
			unique case (reg_idx)
				REG_DIRECTION:  cfg_q.direction  <= pwdata[DIR_W-1:0];
				REG_PLANE_SIZE: cfg_q.plane_size <= pwdata[PLANE_W-1:0];
				REG_CHANNELS:   cfg_q.channels   <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DIRECTION:  prdata = APB_DW'(cfg_q.direction);
			REG_PLANE_SIZE: prdata = APB_DW'(cfg_q.plane_size);
			REG_CHANNELS:   prdata = APB_DW'(cfg_q.channels);
			default:        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Handshake. s1 = RAM read in flight, out = output register.
	// s1 moves on whenever the output register is empty or drains;
	// an input transfer is taken whenever s1 has room next cycle.
	// ---------------------------------------------------------------
	logic s1_v_q, s1_ready_s1, s1_last_s1;
	logic out_v_q, out_ready_q, out_last_q;
	logic [ELEM_OUT_W-1:0] out_data_q;
	logic s1_adv, in_go;

	assign s1_adv        = s1_v_q && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !s1_v_q || s1_adv;
	assign in_go         = s_axis_tvalid && s_axis_tready;

	// ---------------------------------------------------------------
	// Counters / address walk and the element buffer
	// ---------------------------------------------------------------
	tlt_ctl_t          ctl;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [ELEMENT_BITS-1:0] rd_data;

	tlt_walk #(
		.MAX_ELEMS    (MAX_ELEMS),
		.MAX_CHANNELS (MAX_CHANNELS),
		.AW           (AW)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cfg_wr  (cfg_wr),
		.in_go   (in_go),
		.func    (s_axis_tuser),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr)
	);

	// element bits are kept to ELEMENT_BITS (truncate or zero-extend)
	tlt_store #(
		.DEPTH (MAX_ELEMS),
		.WIDTH (ELEMENT_BITS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (wr_addr),
		.wr_data (ELEMENT_BITS'(s_axis_tdata)),
		.rd_en   (ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ---------------------------------------------------------------
	// Result pipeline. Every request yields one result; a request that
	// arrives before the tensor is loaded answers zeros, ready_res low.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_go && (s_axis_tuser == FUNC_REQ)) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_go && (s_axis_tuser == FUNC_REQ)) begin
			s1_ready_s1 <= ctl.ready_res;
			s1_last_s1  <= ctl.last;
		end
		if (s1_adv) begin
			out_data_q  <= s1_ready_s1 ? ELEM_OUT_W'(rd_data) : '0;
			out_ready_q <= s1_ready_s1;
			out_last_q  <= s1_last_s1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ready_q;
	assign m_axis_tlast  = out_last_q;

endmodule
